FILE: hdl/rmsu_pkg.sv
`timescale 1ns / 1ps

package rmsu_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 8'd1;

    // Q0.16 register format
    localparam int unsigned          Q016_W        = 16;
    localparam logic [Q016_W:0]      Q016_ONE      = 17'h1_0000;
    localparam logic [Q016_W-1:0]    LR_RESET      = 16'd66;
    localparam logic [Q016_W-1:0]    DECAY_RESET   = 16'd58982;

    // Control word that travels with every item down the cell chains
    typedef struct packed {
        logic valid;
        logic neg;
        logic sat;
    } rmsu_ctl_t;

endpackage

FILE: hdl/rmsu_sqrt_cell.sv
`timescale 1ns / 1ps

// One digit of the restoring square root: take two radicand bits, make one root bit.
module rmsu_sqrt_cell #(
    parameter int unsigned RW = 24,
    parameter int unsigned PW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rmsu_pkg::rmsu_ctl_t ctl_in,
    input  logic [2*RW-1:0]     x_in,
    input  logic [RW+2:0]       rem_in,
    input  logic [RW-1:0]       q_in,
    input  logic [PW-1:0]       pay_in,
    output rmsu_pkg::rmsu_ctl_t ctl_out,
    output logic [2*RW-1:0]     x_out,
    output logic [RW+2:0]       rem_out,
    output logic [RW-1:0]       q_out,
    output logic [PW-1:0]       pay_out
);

    rmsu_pkg::rmsu_ctl_t ctl_reg;
    logic [2*RW-1:0]     x_reg, x_next;
    logic [RW+2:0]       rem_reg, rem_next, rem_sh, trial;
    logic [RW-1:0]       q_reg, q_next;
    logic [PW-1:0]       pay_reg;
    logic                ge;

    always_comb
    begin
        rem_sh   = {rem_in[RW:0], x_in[2*RW-1 -: 2]};
        trial    = {1'b0, q_in, 2'b01};
        ge       = (rem_sh >= trial);
        rem_next = ge ? (rem_sh - trial) : rem_sh;
        q_next   = {q_in[RW-2:0], ge};
        x_next   = {x_in[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        pay_reg <= pay_in;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign pay_out = pay_reg;

    // Remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid |-> (rem_reg <= {1'b0, q_reg, 1'b0}))
        else $error("sqrt remainder above bound");

endmodule

FILE: hdl/rmsu_div_cell.sv
`timescale 1ns / 1ps

// One step of restoring division: shift in one dividend bit, produce one quotient bit.
module rmsu_div_cell #(
    parameter int unsigned NW = 48,
    parameter int unsigned DW = 24,
    parameter int unsigned PW = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rmsu_pkg::rmsu_ctl_t ctl_in,
    input  logic [NW-1:0]       n_in,
    input  logic [DW-1:0]       rem_in,
    input  logic [DW-1:0]       d_in,
    input  logic [PW-1:0]       pay_in,
    output rmsu_pkg::rmsu_ctl_t ctl_out,
    output logic [NW-1:0]       n_out,
    output logic [DW-1:0]       rem_out,
    output logic [DW-1:0]       d_out,
    output logic [PW-1:0]       pay_out
);

    rmsu_pkg::rmsu_ctl_t ctl_reg;
    logic [NW-1:0]       n_reg, n_next;
    logic [DW-1:0]       rem_reg, rem_next, d_reg;
    logic [DW:0]         rem_sh, diff;
    logic [PW-1:0]       pay_reg;
    logic                ge;

    always_comb
    begin
        rem_sh   = {rem_in, n_in[NW-1]};
        ge       = (rem_sh >= {1'b0, d_in});
        diff     = rem_sh - {1'b0, d_in};
        rem_next = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        // dividend bits leave at the top, quotient bits enter at the bottom
        n_next   = {n_in[NW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        rem_reg <= rem_next;
        d_reg   <= d_in;
        pay_reg <= pay_in;
    end

    assign ctl_out = ctl_reg;
    assign n_out   = n_reg;
    assign rem_out = rem_reg;
    assign d_out   = d_reg;
    assign pay_out = pay_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid |-> (rem_reg < d_reg))
        else $error("division remainder not below divisor");

endmodule

FILE: hdl/rmsprop_update.sv
`timescale 1ns / 1ps
// Pipeline: one square-root cell per root bit and one divider cell per quotient bit.
// Throughput: one item per cycle; busy stays low, results leave on valid for one cycle.
// The receiver cannot stall; every item comes out in order.
// Reset: rst_n clears all valid flags and loads step size = 66, decay_factor = 58982.
module rmsprop_update #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item input
    input  logic                                start,
    output logic                                busy,
    input  logic signed [DATA_WIDTH-1:0]        gradient,
    input  logic signed [DATA_WIDTH-1:0]        weight_in,
    input  logic [DATA_WIDTH-1:0]               square_avg_in,
    // result output
    output logic                                valid,
    output logic signed [DATA_WIDTH-1:0]        weight_out,
    output logic [DATA_WIDTH-1:0]               square_avg_out,
    output logic                                saturated,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rmsu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rmsu_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned W   = DATA_WIDTH;
    localparam int unsigned F   = FRAC_BITS;
    localparam int unsigned QW  = rmsu_pkg::Q016_W;
    // radicand navg << F, root width
    localparam int unsigned XW  = W + F;
    localparam int unsigned RW  = (XW + 1) / 2;
    // dividend lr * |g|
    localparam int unsigned NW  = QW + W;
    // mixing products
    localparam int unsigned MW  = W + QW + 1;
    localparam int unsigned SPW = NW + 2 * W;
    localparam int unsigned DPW = 2 * W;
    localparam int unsigned LAT = RW + NW + 5;

    // ------------------------------------------------------------------
    // Configuration registers: always ready, unknown indexes are dropped
    // ------------------------------------------------------------------
    logic [QW-1:0] lr_reg, decay_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg    <= rmsu_pkg::LR_RESET;
            decay_reg <= rmsu_pkg::DECAY_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == rmsu_pkg::REG_STEP_SIZE)
            begin
                lr_reg <= cfg_data;
            end
            if (cfg_index == rmsu_pkg::REG_DECAY_FACTOR)
            begin
                decay_reg <= cfg_data;
            end
        end
    end

    // Fully pipelined: a new item may enter on every cycle
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: split the gradient into sign and magnitude
    // ------------------------------------------------------------------
    rmsu_pkg::rmsu_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [W-1:0]        gmag1_reg, w1_reg, avg1_reg;
    logic [W-1:0]        gmag_next;

    // the most negative gradient wraps to 2^(W-1), which is its true magnitude
    assign gmag_next = gradient[W-1] ? (W'(0) - W'(gradient)) : W'(gradient);

    always_ff @(posedge clk)
    begin
        gmag1_reg <= gmag_next;
        w1_reg    <= W'(weight_in);
        avg1_reg  <= square_avg_in;
    end

    // ------------------------------------------------------------------
    // Stage 2: square the gradient and form the dividend lr * |g|
    // ------------------------------------------------------------------
    logic [2*W-1:0] sq2_reg;
    logic [NW-1:0]  num2_reg, num3_reg, num4_reg;
    logic [W-1:0]   w2_reg, avg2_reg, w3_reg, w4_reg;

    always_ff @(posedge clk)
    begin
        sq2_reg  <= (2*W)'(gmag1_reg) * (2*W)'(gmag1_reg);
        num2_reg <= NW'(lr_reg) * NW'(gmag1_reg);
        w2_reg   <= w1_reg;
        avg2_reg <= avg1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: clip g*g to range, weight old and new squares
    // ------------------------------------------------------------------
    logic [2*W-1:0] gsq_full;
    logic           gsq_over;
    logic [W-1:0]   gsq;
    logic [QW:0]    keep_new;
    logic [MW-1:0]  pd3_reg, pm3_reg;

    always_comb
    begin
        gsq_full = sq2_reg >> F;
        gsq_over = |gsq_full[2*W-1:W];
        gsq      = gsq_over ? {W{1'b1}} : gsq_full[W-1:0];
        keep_new = rmsu_pkg::Q016_ONE - {1'b0, decay_reg};
    end

    always_ff @(posedge clk)
    begin
        pd3_reg  <= MW'(decay_reg) * MW'(avg2_reg);
        pm3_reg  <= MW'(keep_new) * MW'(gsq);
        num3_reg <= num2_reg;
        w3_reg   <= w2_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: sum the mix and scale back to Q16.16
    // ------------------------------------------------------------------
    logic [MW-1:0] acc;
    logic [W-1:0]  navg4_reg, navg_floor;

    assign acc = pd3_reg + pm3_reg;

    always_ff @(posedge clk)
    begin
        // a convex mix never passes the maximum
        navg4_reg <= acc[W+QW-1:QW];
        num4_reg  <= num3_reg;
        w4_reg    <= w3_reg;
    end

    // epsilon becomes a one-LSB floor under the root
    assign navg_floor = (navg4_reg == '0) ? W'(1) : navg4_reg;

    // control flags for stages 1 to 4
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl1_reg <= '{valid: start, neg: gradient[W-1], sat: 1'b0};
            ctl2_reg <= ctl1_reg;
            // fold the g*g clip into the flag on the way through
            ctl3_reg <= '{valid: ctl2_reg.valid, neg: ctl2_reg.neg,
                          sat: ctl2_reg.sat | gsq_over};
            ctl4_reg <= ctl3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root chain: one cell per root bit
    // ------------------------------------------------------------------
    rmsu_pkg::rmsu_ctl_t sq_ctl [RW+1];
    logic [2*RW-1:0]     sq_x   [RW+1];
    logic [RW+2:0]       sq_rem [RW+1];
    logic [RW-1:0]       sq_q   [RW+1];
    logic [SPW-1:0]      sq_pay [RW+1];

    assign sq_ctl[0] = ctl4_reg;
    assign sq_x[0]   = (2*RW)'({navg_floor, {F{1'b0}}});
    assign sq_rem[0] = '0;
    assign sq_q[0]   = '0;
    assign sq_pay[0] = {num4_reg, w4_reg, navg4_reg};

    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        rmsu_sqrt_cell #(
            .RW (RW),
            .PW (SPW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (sq_ctl[i]),
            .x_in    (sq_x[i]),
            .rem_in  (sq_rem[i]),
            .q_in    (sq_q[i]),
            .pay_in  (sq_pay[i]),
            .ctl_out (sq_ctl[i+1]),
            .x_out   (sq_x[i+1]),
            .rem_out (sq_rem[i+1]),
            .q_out   (sq_q[i+1]),
            .pay_out (sq_pay[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Divider chain: one cell per quotient bit of lr*|g| / root
    // ------------------------------------------------------------------
    rmsu_pkg::rmsu_ctl_t dv_ctl [NW+1];
    logic [NW-1:0]       dv_n   [NW+1];
    logic [RW-1:0]       dv_rem [NW+1];
    logic [RW-1:0]       dv_d   [NW+1];
    logic [DPW-1:0]      dv_pay [NW+1];

    assign dv_ctl[0] = sq_ctl[RW];
    assign dv_n[0]   = sq_pay[RW][SPW-1 -: NW];
    assign dv_rem[0] = '0;
    assign dv_d[0]   = sq_q[RW];
    assign dv_pay[0] = sq_pay[RW][DPW-1:0];

    for (genvar j = 0; j < NW; j++)
    begin : g_div
        rmsu_div_cell #(
            .NW (NW),
            .DW (RW),
            .PW (DPW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (dv_ctl[j]),
            .n_in    (dv_n[j]),
            .rem_in  (dv_rem[j]),
            .d_in    (dv_d[j]),
            .pay_in  (dv_pay[j]),
            .ctl_out (dv_ctl[j+1]),
            .n_out   (dv_n[j+1]),
            .rem_out (dv_rem[j+1]),
            .d_out   (dv_d[j+1]),
            .pay_out (dv_pay[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Final stage: clip the step, apply it, clip the weight
    // ------------------------------------------------------------------
    rmsu_pkg::rmsu_ctl_t fin_ctl;
    logic [NW-1:0]  quot;
    logic           mag_over, w_over;
    logic [W-1:0]   mag, w_fin, navg_fin, w_new;
    logic [W:0]     step, diff;

    always_comb
    begin
        fin_ctl  = dv_ctl[NW];
        quot     = dv_n[NW];
        w_fin    = dv_pay[NW][DPW-1:W];
        navg_fin = dv_pay[NW][W-1:0];
        mag_over = |quot[NW-1:W-1];
        mag      = mag_over ? {1'b0, {(W-1){1'b1}}} : quot[W-1:0];
        step     = fin_ctl.neg ? ((W+1)'(0) - (W+1)'(mag)) : (W+1)'(mag);
        diff     = {w_fin[W-1], w_fin} - step;
        w_over   = (diff[W] != diff[W-1]);
        // the sign bit of the wide difference picks the limit
        w_new    = w_over ? {diff[W], {(W-1){~diff[W]}}} : diff[W-1:0];
    end

    logic         valid_reg;
    logic [W-1:0] weight_reg, avg_reg;
    logic         sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= fin_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= w_new;
        avg_reg    <= navg_fin;
        sat_reg    <= fin_ctl.sat | mag_over | w_over;
    end

    assign valid          = valid_reg;
    assign weight_out     = weight_reg;
    assign square_avg_out = avg_reg;
    assign saturated      = sat_reg;

    // Every result strobe traces back to an accepted item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(start, LAT))
        else $error("result without a matching item");

    // A zero gradient leaves the weight unchanged and clips nothing
    a_zero_grad: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ($past(gradient, LAT) == '0)
            |-> (weight_out == $past(weight_in, LAT)) && !saturated)
        else $error("zero gradient changed the weight");

endmodule
